// ===== design/akd_pkg.sv =====
// Shared constants, payload types and controller encodings for the window counter.
package akd_pkg;

	localparam int MAX_LEN    = 4096;
	localparam int VALUE_BITS = 10;
	localparam int NUM_VALUES = 1 << VALUE_BITS;

	// fixed field widths
	localparam int VALUE_W = 10;
	localparam int HERE_W  = 13;
	localparam int TOTAL_W = 24;
	localparam int CFG_W   = 11;

	// derived widths
	localparam int POS_W  = $clog2(MAX_LEN + 1);   // holds 0..MAX_LEN
	localparam int ADDR_W = $clog2(MAX_LEN);       // window store address
	localparam int VAL_AW = VALUE_BITS;            // count table address
	localparam int CNT_W  = POS_W;                 // per-value occurrence count

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               first;
	} item_t;

	typedef struct packed {
		logic [HERE_W-1:0]  ending_here;
		logic [TOTAL_W-1:0] running_total;
		logic [CFG_W-1:0]   distinct_now;
		logic               overflow;
	} result_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DRAIN_CHK,
		ST_DRAIN_WR,
		ST_CHK,
		ST_ADD,
		ST_SHR_CHK,
		ST_SHR_CNT,
		ST_SHR_UPD,
		ST_FINISH
	} ctrl_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LATCH,
		OP_DRAIN_WR,
		OP_SEQ_CLR,
		OP_PUSH,
		OP_ADD,
		OP_SHR_CNT,
		OP_SHR_UPD,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_last;   // reset clearing pass at last table entry
		logic drain_more;   // new sequence and old window not yet empty
		logic full;         // sequence already holds MAX_LEN elements
		logic shrink_more;  // window must drop its front element
		logic out_busy;     // result register still holds an untaken result
	} dp_status_t;

endpackage

// ===== design/akd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module akd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/akd_ctrl.sv =====
// Controller state machine: sequences clearing, draining, insert and shrink steps.
module akd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  akd_pkg::dp_status_t status,
	output akd_pkg::dp_cmd_t   cmd
);

	akd_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= akd_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd.op     = akd_pkg::OP_NONE;
		item_ready = 1'b0;
		case (state_q)
			akd_pkg::ST_CLEAR: begin
				cmd.op = akd_pkg::OP_CLEAR;
				if (status.clear_last) begin
					state_d = akd_pkg::ST_IDLE;
				end
			end
			akd_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.op  = akd_pkg::OP_LATCH;
					state_d = akd_pkg::ST_DRAIN_CHK;
				end
			end
			akd_pkg::ST_DRAIN_CHK: begin
				// store read of the front element is always in flight
				if (status.drain_more) begin
					state_d = akd_pkg::ST_DRAIN_WR;
				end else begin
					cmd.op  = akd_pkg::OP_SEQ_CLR;
					state_d = akd_pkg::ST_CHK;
				end
			end
			akd_pkg::ST_DRAIN_WR: begin
				cmd.op  = akd_pkg::OP_DRAIN_WR;
				state_d = akd_pkg::ST_DRAIN_CHK;
			end
			akd_pkg::ST_CHK: begin
				if (status.full) begin
					state_d = akd_pkg::ST_FINISH;
				end else begin
					cmd.op  = akd_pkg::OP_PUSH;
					state_d = akd_pkg::ST_ADD;
				end
			end
			akd_pkg::ST_ADD: begin
				cmd.op  = akd_pkg::OP_ADD;
				state_d = akd_pkg::ST_SHR_CHK;
			end
			akd_pkg::ST_SHR_CHK: begin
				if (status.shrink_more) begin
					state_d = akd_pkg::ST_SHR_CNT;
				end else begin
					state_d = akd_pkg::ST_FINISH;
				end
			end
			akd_pkg::ST_SHR_CNT: begin
				cmd.op  = akd_pkg::OP_SHR_CNT;
				state_d = akd_pkg::ST_SHR_UPD;
			end
			akd_pkg::ST_SHR_UPD: begin
				cmd.op  = akd_pkg::OP_SHR_UPD;
				state_d = akd_pkg::ST_SHR_CHK;
			end
			akd_pkg::ST_FINISH: begin
				if (!status.out_busy) begin
					cmd.op  = akd_pkg::OP_FINISH;
					state_d = akd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = akd_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/akd_dp.sv =====
// Datapath: window store, count table, window bounds, totals and result register.
module akd_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  akd_pkg::dp_cmd_t            cmd,
	output akd_pkg::dp_status_t         status,
	input  akd_pkg::item_t              item,
	input  logic                        cfg_valid,
	input  logic [akd_pkg::CFG_W-1:0]   cfg_data,
	output akd_pkg::result_t            result,
	output logic                        result_valid,
	input  logic                        result_ready
);

	logic [akd_pkg::CFG_W-1:0]      max_distinct_q;
	logic [akd_pkg::VALUE_BITS-1:0] v_q;
	logic                           first_q;
	logic [akd_pkg::POS_W-1:0]      start_q;
	logic [akd_pkg::POS_W-1:0]      end_q;
	logic [akd_pkg::CFG_W-1:0]      distinct_q;
	logic [akd_pkg::TOTAL_W-1:0]    total_q;
	logic [akd_pkg::VAL_AW-1:0]     clr_idx_q;
	logic [akd_pkg::VAL_AW-1:0]     old_q;
	akd_pkg::result_t               result_q;
	logic                           result_valid_q;

	logic [akd_pkg::VALUE_BITS-1:0] ws_rdata;
	logic                           ws_we;
	logic [akd_pkg::CNT_W-1:0]      cnt_rdata;
	logic                           cnt_we;
	logic [akd_pkg::VAL_AW-1:0]     cnt_waddr;
	logic [akd_pkg::CNT_W-1:0]      cnt_wdata;
	logic [akd_pkg::VAL_AW-1:0]     cnt_raddr;
	logic [akd_pkg::POS_W-1:0]      here;
	logic [akd_pkg::TOTAL_W-1:0]    total_next;

	// window store read port always follows the window front
	assign ws_we = (cmd.op == akd_pkg::OP_PUSH);

	akd_ram #(
		.WIDTH(akd_pkg::VALUE_BITS),
		.DEPTH(akd_pkg::MAX_LEN)
	) u_window_store (
		.clk  (clk),
		.we   (ws_we),
		.waddr(end_q[akd_pkg::ADDR_W-1:0]),
		.wdata(v_q),
		.raddr(start_q[akd_pkg::ADDR_W-1:0]),
		.rdata(ws_rdata)
	);

	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = v_q;
		cnt_wdata = '0;
		case (cmd.op)
			akd_pkg::OP_CLEAR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_idx_q;
			end
			akd_pkg::OP_DRAIN_WR: begin
				cnt_we    = 1'b1;
				cnt_waddr = ws_rdata;
			end
			akd_pkg::OP_ADD: begin
				cnt_we    = 1'b1;
				cnt_wdata = cnt_rdata + akd_pkg::CNT_W'(1);
			end
			akd_pkg::OP_SHR_UPD: begin
				cnt_we    = (cnt_rdata != '0);
				cnt_waddr = old_q;
				cnt_wdata = cnt_rdata - akd_pkg::CNT_W'(1);
			end
			default: begin
				cnt_we = 1'b0;
			end
		endcase
	end

	assign cnt_raddr = (cmd.op == akd_pkg::OP_SHR_CNT) ? ws_rdata : v_q;

	akd_ram #(
		.WIDTH(akd_pkg::CNT_W),
		.DEPTH(akd_pkg::NUM_VALUES)
	) u_value_counts (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.raddr(cnt_raddr),
		.rdata(cnt_rdata)
	);

	assign here       = end_q + akd_pkg::POS_W'(1) - start_q;
	assign total_next = total_q + akd_pkg::TOTAL_W'(here);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_distinct_q <= akd_pkg::CFG_W'(1);
			start_q        <= '0;
			end_q          <= '0;
			distinct_q     <= '0;
			total_q        <= '0;
			clr_idx_q      <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				max_distinct_q <= cfg_data;
			end
			// a new result wins over the handoff of the old one
			if (cmd.op == akd_pkg::OP_FINISH) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (cmd.op)
				akd_pkg::OP_CLEAR: begin
					clr_idx_q <= clr_idx_q + akd_pkg::VAL_AW'(1);
				end
				akd_pkg::OP_DRAIN_WR: begin
					start_q <= start_q + akd_pkg::POS_W'(1);
				end
				akd_pkg::OP_SEQ_CLR: begin
					if (first_q) begin
						start_q    <= '0;
						end_q      <= '0;
						distinct_q <= '0;
						total_q    <= '0;
					end
				end
				akd_pkg::OP_ADD: begin
					if (cnt_rdata == '0) begin
						distinct_q <= distinct_q + akd_pkg::CFG_W'(1);
					end
				end
				akd_pkg::OP_SHR_UPD: begin
					if (cnt_rdata == akd_pkg::CNT_W'(1)) begin
						distinct_q <= distinct_q - akd_pkg::CFG_W'(1);
					end
					start_q <= start_q + akd_pkg::POS_W'(1);
				end
				akd_pkg::OP_FINISH: begin
					if (!status.full) begin
						end_q   <= end_q + akd_pkg::POS_W'(1);
						total_q <= total_next;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.op == akd_pkg::OP_LATCH) begin
			v_q     <= item.value[akd_pkg::VALUE_BITS-1:0];
			first_q <= item.first;
		end
		if (cmd.op == akd_pkg::OP_SHR_CNT) begin
			old_q <= ws_rdata;
		end
		if (cmd.op == akd_pkg::OP_FINISH) begin
			result_q.distinct_now <= distinct_q;
			if (status.full) begin
				result_q.ending_here   <= '0;
				result_q.running_total <= total_q;
				result_q.overflow      <= 1'b1;
			end else begin
				result_q.ending_here   <= akd_pkg::HERE_W'(here);
				result_q.running_total <= total_next;
				result_q.overflow      <= 1'b0;
			end
		end
	end

	assign status.clear_last  = (clr_idx_q == akd_pkg::VAL_AW'(akd_pkg::NUM_VALUES - 1));
	assign status.drain_more  = first_q && (start_q < end_q);
	assign status.full        = (end_q >= akd_pkg::POS_W'(akd_pkg::MAX_LEN));
	assign status.shrink_more = (start_q <= end_q) && (distinct_q > max_distinct_q);
	assign status.out_busy    = result_valid_q && !result_ready;

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

// ===== design/at_most_k_distinct_window_counter.sv =====
// Top level of the at-most-k-distinct sliding window counter.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------
//  item     | item_valid / item_ready    | item   (value, first)
//  result   | result_valid / result_ready| result (ending_here, running_total,
//           |                            |         distinct_now, overflow)
//  cfg      | cfg_valid / cfg_ready      | cfg_data (max_distinct), always ready
//
// One transaction at a time. An ordinary element passes the drain check, full check
// with store write, count update, shrink check and finish step; then result_valid
// and item_ready assert together. Each element dropped from the window front adds a
// shrink check, count read and count write; each element is dropped at most once
// per sequence. An element past MAX_LEN skips insert and shrink. With first set, a
// transaction adds a drain check and drain write per element still in the old
// window, as the count table entries are zeroed one by one through its single
// write port. After reset a clearing pass zeroes the 1024-entry count table, one
// entry a cycle, with item_ready low until it ends; cfg writes are taken throughout.
// The result register lets the next transaction be accepted while a result waits;
// the machine stalls only when a new result is ready and the old one is untaken.
module at_most_k_distinct_window_counter (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  akd_pkg::item_t             item,
	output logic                       result_valid,
	input  logic                       result_ready,
	output akd_pkg::result_t           result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [akd_pkg::CFG_W-1:0]  cfg_data
);

	akd_pkg::dp_cmd_t    cmd;
	akd_pkg::dp_status_t status;

	// the limit register takes a write in any cycle
	assign cfg_ready = 1'b1;

	akd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.status    (status),
		.cmd       (cmd)
	);

	akd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.item        (item),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.result      (result),
		.result_valid(result_valid),
		.result_ready(result_ready)
	);

	// one transaction in flight: the controller leaves idle right after an accept
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item accepted twice in a row");

	// an ignored element never reports subarrays
	a_overflow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.overflow |-> result.ending_here == '0)
		else $error("overflow result with nonzero count");

	// the window never spans more than the store
	a_here_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.ending_here <= akd_pkg::HERE_W'(akd_pkg::MAX_LEN))
		else $error("ending_here beyond window capacity");

	// an empty distinct set means an empty window
	a_empty_window: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.overflow && result.distinct_now == '0
		|-> result.ending_here == '0)
		else $error("nonempty window with no distinct values");

endmodule
